>>> src/alm_pkg.sv
// Shared constants, types and control structs for the audio level meter.
package alm_pkg;

  // Buffer and sample geometry
  localparam int MAX_FRAMES  = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
  localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);

  // Accumulator widths: exact for a full buffer of worst-case samples
  localparam int SQ_W  = 2 * (SAMPLE_W - 1) + FRAME_IDX_W + 1;
  localparam int SUM_W = SAMPLE_W + FRAME_IDX_W + 1;

  // Result field widths
  localparam int LEN_W   = 13;
  localparam int BUF_W   = 32;
  localparam int FRAME_W = 48;

  // Iterative unit sizing
  localparam int ROOT_IN_W = 2 * SAMPLE_W;
  localparam int REM_W     = SAMPLE_W + 4;
  localparam int STEP_W    = $clog2(SQ_W + 1);

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } alm_op_e;

  // Command to the shared divide / square-root unit
  typedef struct packed {
    logic                start;
    alm_op_e             op;
    logic [SQ_W-1:0]     operand;
    logic [COUNT_W-1:0]  divisor;
    logic [STEP_W-1:0]   steps;
  } alm_cmd_t;

  // Status back from the shared unit
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [SQ_W-1:0] result;
  } alm_rsp_t;

  // Control into the accumulator
  typedef struct packed {
    logic                       upd;
    logic                       clr;
    logic                       last;
    logic signed [SAMPLE_W-1:0] sample;
  } alm_acc_ctl_t;

  // Accumulator contents
  typedef struct packed {
    logic [SAMPLE_W-1:0]     peak;
    logic [SQ_W-1:0]         sq_sum;
    logic signed [SUM_W-1:0] sum;
    logic [COUNT_W-1:0]      count;
    logic                    ovf;
    logic [BUF_W-1:0]        buf_cnt;
    logic [FRAME_W-1:0]      frame_cnt;
  } alm_acc_t;

endpackage

>>> src/audio_level_meter.sv
// Top level: audio peak / RMS / DC level meter with sequencer and output register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_ready_o | sample_i, last_i
//   out     | output    | out_valid_o/out_ready_i | peak, rms, dc, length, totals, too_long
//
// A sample without last is accepted and then accumulated.
// A last sample is accepted, accumulated and launched, then the shared unit runs a
// 43-step divide for the mean square, a 16-step square root and a 28-step divide for the DC
// mean one after another, each ending in a done strobe, and the finishing state loads the result.
// in_ready_o is high only while the sequencer is idle; a result waits in the output
// register and only the next buffer end stalls on it.
// Reset clears the peak hold, the sums and both totals; no clearing pass is needed.
module audio_level_meter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        peak_mag_o,
  output logic [15:0]        rms_mag_o,
  output logic signed [15:0] dc_mean_o,
  output logic [12:0]        buffer_length_o,
  output logic [31:0]        buffer_total_o,
  output logic [47:0]        frames_total_o,
  output logic               too_long_o
);
  import alm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_LAUNCH,
    S_MSDIV,
    S_SQRT,
    S_DCDIV,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic signed [SAMPLE_W-1:0] s_q;
  logic                    last_q;
  logic [SAMPLE_W-1:0]     rms_q;
  logic [SAMPLE_W-1:0]     dc_q;

  logic                    o_valid_q;
  logic [SAMPLE_W-1:0]     o_peak_q;
  logic [SAMPLE_W-1:0]     o_rms_q;
  logic [SAMPLE_W-1:0]     o_dc_q;
  logic [LEN_W-1:0]        o_len_q;
  logic [BUF_W-1:0]        o_buf_q;
  logic [FRAME_W-1:0]      o_frames_q;
  logic                    o_long_q;

  alm_acc_ctl_t            acc_ctl;
  alm_acc_t                acc;
  alm_cmd_t                cmd;
  alm_rsp_t                rsp;

  logic                    in_xact;
  logic                    fin_load;
  logic [SUM_W-1:0]        sum_abs;
  logic [SAMPLE_W-1:0]     dc_mag;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xact    = in_valid_i && in_ready_o;
  assign fin_load   = (state_q == S_FIN) && (!o_valid_q || out_ready_i);

  assign sum_abs = acc.sum[SUM_W-1] ? (~acc.sum + 1'b1) : acc.sum;
  assign dc_mag  = rsp.result[SAMPLE_W-1:0];

  // Accumulator control
  assign acc_ctl.upd    = (state_q == S_ACC);
  assign acc_ctl.clr    = fin_load;
  assign acc_ctl.last   = last_q;
  assign acc_ctl.sample = s_q;

  alm_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (acc_ctl),
    .acc_o  (acc)
  );

  // Commands to the shared unit, issued on each state hand-off
  always_comb begin
    cmd.start   = 1'b0;
    cmd.op      = OP_DIV;
    cmd.operand = acc.sq_sum;
    cmd.divisor = acc.count;
    cmd.steps   = STEP_W'(SQ_W);
    unique case (state_q)
      S_LAUNCH: begin
        cmd.start = 1'b1;
      end
      S_MSDIV: begin
        cmd.start   = rsp.done;
        cmd.op      = OP_SQRT;
        cmd.operand = {rsp.result[ROOT_IN_W-1:0], {(SQ_W-ROOT_IN_W){1'b0}}};
        cmd.steps   = STEP_W'(SAMPLE_W);
      end
      S_SQRT: begin
        cmd.start   = rsp.done;
        cmd.operand = {sum_abs[SUM_W-2:0], {(SQ_W-SUM_W+1){1'b0}}};
        cmd.steps   = STEP_W'(SUM_W - 1);
      end
      S_IDLE, S_ACC, S_DCDIV, S_FIN: begin
        cmd.start = 1'b0;
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  alm_itu u_itu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      s_q        <= '0;
      last_q     <= 1'b0;
      rms_q      <= '0;
      dc_q       <= '0;
      o_valid_q  <= 1'b0;
      o_peak_q   <= '0;
      o_rms_q    <= '0;
      o_dc_q     <= '0;
      o_len_q    <= '0;
      o_buf_q    <= '0;
      o_frames_q <= '0;
      o_long_q   <= 1'b0;
    end else begin
      // A new result loaded in the same cycle keeps valid high
      if (o_valid_q && out_ready_i && !fin_load) begin
        o_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xact) begin
            s_q     <= sample_i;
            last_q  <= last_i;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          state_q <= last_q ? S_LAUNCH : S_IDLE;
        end
        S_LAUNCH: begin
          state_q <= S_MSDIV;
        end
        S_MSDIV: begin
          if (rsp.done) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rsp.done) begin
            rms_q   <= rsp.result[SAMPLE_W-1:0];
            state_q <= S_DCDIV;
          end
        end
        S_DCDIV: begin
          if (rsp.done) begin
            dc_q    <= acc.sum[SUM_W-1] ? (~dc_mag + 1'b1) : dc_mag;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            o_valid_q  <= 1'b1;
            o_peak_q   <= acc.peak;
            o_rms_q    <= rms_q;
            o_dc_q     <= dc_q;
            o_len_q    <= LEN_W'(acc.count);
            o_buf_q    <= acc.buf_cnt;
            o_frames_q <= acc.frame_cnt;
            o_long_q   <= acc.ovf;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = o_valid_q;
  assign peak_mag_o      = o_peak_q;
  assign rms_mag_o       = o_rms_q;
  assign dc_mean_o       = $signed(o_dc_q);
  assign buffer_length_o = o_len_q;
  assign buffer_total_o  = o_buf_q;
  assign frames_total_o  = o_frames_q;
  assign too_long_o      = o_long_q;

`ifndef SYNTH
  // The block only takes samples while the shared unit is quiet
  a_ready_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rsp.busy)
    else $error("audio_level_meter: ready while unit busy");

  // A new result is only loaded from the finishing state
  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(o_valid_q) |-> $past(state_q == S_FIN))
    else $error("audio_level_meter: result loaded outside finish");
`endif

endmodule

>>> src/alm_itu.sv
// Shared iterative unit: restoring divide (one bit per cycle) and square root (one digit per cycle).
module alm_itu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alm_pkg::alm_cmd_t cmd_i,
  output alm_pkg::alm_rsp_t rsp_o
);
  import alm_pkg::*;

  logic [SQ_W-1:0]    src_q, src_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [SQ_W-1:0]    res_q, res_d;
  logic [COUNT_W-1:0] div_q, div_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  alm_op_e            op_q, op_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [REM_W-1:0]   shifted;
  logic [REM_W-1:0]   trial;
  logic               ge;

  // Shift in the next operand bits and try the subtraction
  always_comb begin
    if (op_q == OP_SQRT) begin
      shifted = {rem_q[REM_W-3:0], src_q[SQ_W-1 -: 2]};
      trial   = {res_q[REM_W-3:0], 2'b01};
    end else begin
      shifted = {rem_q[REM_W-2:0], src_q[SQ_W-1]};
      trial   = REM_W'(div_q);
    end
    ge = (shifted >= trial);
  end

  // Sequencing: load on start, then one step per cycle
  always_comb begin
    src_d  = src_q;
    rem_d  = rem_q;
    res_d  = res_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      src_d  = cmd_i.operand;
      rem_d  = '0;
      res_d  = '0;
      div_d  = cmd_i.divisor;
      cnt_d  = cmd_i.steps;
      op_d   = cmd_i.op;
      busy_d = 1'b1;
    end else if (busy_q) begin
      src_d = (op_q == OP_SQRT) ? (src_q << 2) : (src_q << 1);
      rem_d = ge ? (shifted - trial) : shifted;
      res_d = {res_q[SQ_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= '0;
      rem_q  <= '0;
      res_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      src_q  <= src_d;
      rem_q  <= rem_d;
      res_q  <= res_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

`ifndef SYNTH
  // A new operation is never launched over one in flight
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("alm_itu: start while busy");

  // Restoring divide keeps the partial remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == OP_DIV) |-> (rem_q < REM_W'(div_q)))
    else $error("alm_itu: divide remainder out of range");
`endif

endmodule

>>> src/alm_acc.sv
// Per-buffer sums, session peak hold and saturating transaction counters.
module alm_acc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  alm_pkg::alm_acc_ctl_t ctl_i,
  output alm_pkg::alm_acc_t     acc_o
);
  import alm_pkg::*;

  logic [SAMPLE_W-1:0]     peak_q, peak_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic                    ovf_q, ovf_d;
  logic [BUF_W-1:0]        buf_q, buf_d;
  logic [FRAME_W-1:0]      frame_q, frame_d;

  logic [SAMPLE_W-1:0]     mag;
  logic [2*SAMPLE_W-1:0]   mag_sq;

  // Magnitude and its square; the most negative sample maps to 2^(SAMPLE_W-1)
  assign mag    = ctl_i.sample[SAMPLE_W-1] ? (~ctl_i.sample + 1'b1) : ctl_i.sample;
  assign mag_sq = mag * mag;

  always_comb begin
    peak_d  = peak_q;
    sq_d    = sq_q;
    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    buf_d   = buf_q;
    frame_d = frame_q;
    if (ctl_i.upd) begin
      if (mag > peak_q) begin
        peak_d = mag;
      end
      // Samples past a full buffer touch only the peak hold, the overflow flag and the buffer count
      if (count_q < COUNT_W'(MAX_FRAMES)) begin
        sq_d    = sq_q + SQ_W'(mag_sq);
        sum_d   = sum_q + SUM_W'($signed(ctl_i.sample));
        count_d = count_q + 1'b1;
        if (frame_q != {FRAME_W{1'b1}}) begin
          frame_d = frame_q + 1'b1;
        end
      end else begin
        ovf_d = 1'b1;
      end
      if (ctl_i.last && (buf_q != {BUF_W{1'b1}})) begin
        buf_d = buf_q + 1'b1;
      end
    end else if (ctl_i.clr) begin
      sq_d    = '0;
      sum_d   = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      sq_q    <= '0;
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      buf_q   <= '0;
      frame_q <= '0;
    end else begin
      peak_q  <= peak_d;
      sq_q    <= sq_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      buf_q   <= buf_d;
      frame_q <= frame_d;
    end
  end

  assign acc_o.peak      = peak_q;
  assign acc_o.sq_sum    = sq_q;
  assign acc_o.sum       = sum_q;
  assign acc_o.count     = count_q;
  assign acc_o.ovf       = ovf_q;
  assign acc_o.buf_cnt   = buf_q;
  assign acc_o.frame_cnt = frame_q;

`ifndef SYNTH
  // Count never passes the buffer limit
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(MAX_FRAMES))
    else $error("alm_acc: sample count above limit");

  // A clear leaves an empty buffer behind
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.clr && !ctl_i.upd) |=> (count_q == '0 && !ovf_q))
    else $error("alm_acc: buffer not cleared");
`endif

endmodule
